// ----- hdl/tlb_page_replacement_mmu_macros.svh -----
// Assertion macros shared by the checker.
`ifndef TLB_PAGE_REPLACEMENT_MMU_MACROS_SVH
`define TLB_PAGE_REPLACEMENT_MMU_MACROS_SVH

// Same-cycle implication, off during reset.
`define TPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpr assertion failed");

// Next-cycle implication, off during reset.
`define TPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpr assertion failed");

`endif

// ----- hdl/tpr_pkg.sv -----
`default_nettype none
package tpr_pkg;

    localparam int VIRTUAL_PAGES = 1024;
    localparam int FRAMES        = 64;
    localparam int TLB_ENTRIES   = 16;

    localparam int PAGE_W  = $clog2(VIRTUAL_PAGES);
    localparam int FRAME_W = 6;
    localparam int FIDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int SLOT_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int STAMP_W = 32;
    localparam int COUNT_W = 32;
    localparam int ADDR_W  = 32;
    localparam int CLR_W   = $clog2(VIRTUAL_PAGES) + 1;
    localparam int SCAN_W  = $clog2(FRAMES + TLB_ENTRIES + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_POLICY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TLB_POLICY  = 2'd2;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_LOOK  = 8'b0000_0100,
        ST_PT    = 8'b0000_1000,
        ST_FR    = 8'b0001_0000,
        ST_PTWR  = 8'b0010_0000,
        ST_FSCAN = 8'b0100_0000,
        ST_TSCAN = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic               resident;
        logic [FIDX_W-1:0]  frame;
    } pte_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  owner;
        logic [STAMP_W-1:0] stamp;
    } fte_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == '1) ? v : v + 32'd1;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tlb_page_replacement_mmu.sv -----
`default_nettype none
// Virtual address translator with a 16-slot TLB, a 1024-entry page table and
// 64 frames. After reset a clearing pass loads the page table; busy stays
// high through it. Pulse start while busy is low to hand in a word; its
// result comes back on done for one cycle, and the receiver cannot stall,
// so take it then. A TLB hit needs only the lookup; a miss also reads the
// page table and the frame memory, and a page fault adds a page table write.
// LRU frame choice adds a scan of the frame memory stamps, one stamp a cycle;
// LRU TLB choice adds a slot scan (on hits too). The next word may be started
// in the cycle done is high. Register writes are taken only while busy is low.
module tlb_page_replacement_mmu
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output      logic                           busy,
    input  wire logic [tpr_pkg::ADDR_W-1:0]     address,
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data,
    output      logic                           done,
    output      logic [tpr_pkg::FRAME_W-1:0]    frame,
    output      logic                           tlb_hit,
    output      logic                           page_fault,
    output      logic                           out_of_range,
    output      logic [tpr_pkg::COUNT_W-1:0]    tlb_miss_total,
    output      logic [tpr_pkg::COUNT_W-1:0]    page_fault_total
);
    import tpr_pkg::*;

    state_t state_reg, state_next;

    logic [4:0]          page_shift_reg;
    logic                page_policy_reg;
    logic                tlb_policy_reg;

    logic [PAGE_W-1:0]   tlb_page_reg  [TLB_ENTRIES];
    logic [FIDX_W-1:0]   tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [STAMP_W-1:0]  tlb_stamp_reg [TLB_ENTRIES];
    logic [SLOT_W-1:0]   tlb_victim_reg;
    logic [FIDX_W-1:0]   frame_victim_reg;
    logic [STAMP_W-1:0]  page_clock_reg;
    logic [STAMP_W-1:0]  tlb_clock_reg;
    logic [COUNT_W-1:0]  miss_count_reg;
    logic [COUNT_W-1:0]  fault_count_reg;

    logic [CLR_W-1:0]    clr_cnt_reg;
    logic [SCAN_W-1:0]   scan_cnt_reg;
    logic [STAMP_W-1:0]  best_stamp_reg;
    logic [PAGE_W-1:0]   pg_reg;
    logic                oor_reg;
    logic [FIDX_W-1:0]   f_reg;
    logic                fault_reg;
    logic                hit_reg;
    logic [FIDX_W-1:0]   res_frame_reg;
    logic                done_reg;

    pte_t                pt_mem [VIRTUAL_PAGES];
    pte_t                pt_rdata_reg;
    fte_t                fr_mem [FRAMES];
    fte_t                fr_rdata_reg;

    logic [ADDR_W-1:0]   pg_full;
    logic                hit_any;
    logic [SLOT_W-1:0]   hit_idx;
    logic [FIDX_W-1:0]   f_sel;
    logic                pt_we;
    logic [PAGE_W-1:0]   pt_waddr;
    pte_t                pt_wdata;
    logic                fr_we;
    logic [FIDX_W-1:0]   fr_waddr;
    fte_t                fr_wdata;
    logic [FIDX_W-1:0]   fr_raddr;
    logic [STAMP_W-1:0]  page_clock_inc;
    logic [STAMP_W-1:0]  tlb_clock_inc;
    logic [FIDX_W-1:0]   fs_idx;
    logic                fs_take;
    logic [STAMP_W-1:0]  ts_stamp;
    logic                ts_take;
    logic                clr_low;
    state_t              after_tlb;
    state_t              after_frame;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign frame     = FRAME_W'(res_frame_reg);
    assign tlb_hit   = hit_reg;
    assign page_fault = fault_reg;
    assign out_of_range = oor_reg;
    assign tlb_miss_total   = miss_count_reg;
    assign page_fault_total = fault_count_reg;

    assign pg_full        = address >> page_shift_reg;
    assign page_clock_inc = sat_inc(page_clock_reg);
    assign tlb_clock_inc  = sat_inc(tlb_clock_reg);
    assign f_sel          = pt_rdata_reg.resident ? pt_rdata_reg.frame : frame_victim_reg;
    assign fs_idx         = FIDX_W'(scan_cnt_reg - SCAN_W'(1));
    assign fs_take        = (scan_cnt_reg == SCAN_W'(1)) ||
                            (fr_rdata_reg.stamp < best_stamp_reg);
    assign ts_stamp       = tlb_stamp_reg[scan_cnt_reg[SLOT_W-1:0]];
    assign ts_take        = (scan_cnt_reg == '0) || (ts_stamp < best_stamp_reg);
    assign clr_low        = (clr_cnt_reg < CLR_W'(FRAMES));
    assign after_tlb      = tlb_policy_reg ? ST_TSCAN : ST_IDLE;
    assign after_frame    = page_policy_reg ? ST_FSCAN : after_tlb;

    // First valid slot holding the page; lowest index wins.
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--)
        begin
            if (tlb_valid_reg[k] && tlb_page_reg[k] == pg_reg)
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == CLR_W'(VIRTUAL_PAGES - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (start)
                    state_next = ST_LOOK;
            ST_LOOK:
                if (oor_reg)
                    state_next = ST_IDLE;
                else if (hit_any)
                    state_next = after_tlb;
                else
                    state_next = ST_PT;
            ST_PT:
                state_next = ST_FR;
            ST_FR:
                state_next = fault_reg ? ST_PTWR : after_frame;
            ST_PTWR:
                state_next = after_frame;
            ST_FSCAN:
                if (scan_cnt_reg == SCAN_W'(FRAMES))
                    state_next = after_tlb;
            ST_TSCAN:
                if (scan_cnt_reg == SCAN_W'(TLB_ENTRIES - 1))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Memory ports.
    always_comb
    begin
        pt_we    = 1'b0;
        pt_waddr = pg_reg;
        pt_wdata = '0;
        fr_we    = 1'b0;
        fr_waddr = f_reg;
        fr_wdata = '0;
        fr_raddr = scan_cnt_reg[FIDX_W-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                pt_we             = 1'b1;
                pt_waddr          = clr_cnt_reg[PAGE_W-1:0];
                pt_wdata.resident = clr_low;
                pt_wdata.frame    = clr_low ? clr_cnt_reg[FIDX_W-1:0] : '0;
                fr_we             = clr_low;
                fr_waddr          = clr_cnt_reg[FIDX_W-1:0];
                fr_wdata.owner    = clr_cnt_reg[PAGE_W-1:0];
                fr_wdata.stamp    = '0;
            end
            ST_PT:
                fr_raddr = f_sel;
            ST_FR:
            begin
                // Drop the evicted page from the table.
                pt_we          = fault_reg;
                pt_waddr       = fr_rdata_reg.owner;
                pt_wdata       = '0;
                fr_we          = 1'b1;
                fr_wdata.owner = fault_reg ? pg_reg : fr_rdata_reg.owner;
                fr_wdata.stamp = page_policy_reg ? page_clock_inc : fr_rdata_reg.stamp;
            end
            ST_PTWR:
            begin
                pt_we             = 1'b1;
                pt_wdata.resident = 1'b1;
                pt_wdata.frame    = f_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_waddr] <= pt_wdata;
        pt_rdata_reg <= pt_mem[pg_reg];
        if (fr_we)
            fr_mem[fr_waddr] <= fr_wdata;
        fr_rdata_reg <= fr_mem[fr_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            page_shift_reg   <= '0;
            page_policy_reg  <= 1'b0;
            tlb_policy_reg   <= 1'b0;
            for (int k = 0; k < TLB_ENTRIES; k++)
            begin
                tlb_page_reg[k]  <= PAGE_W'(k);
                tlb_frame_reg[k] <= FIDX_W'(k);
                tlb_valid_reg[k] <= (k < FRAMES) && (k < VIRTUAL_PAGES);
                tlb_stamp_reg[k] <= '0;
            end
            tlb_victim_reg   <= '0;
            frame_victim_reg <= '0;
            page_clock_reg   <= '0;
            tlb_clock_reg    <= '0;
            miss_count_reg   <= '0;
            fault_count_reg  <= '0;
            clr_cnt_reg      <= '0;
            scan_cnt_reg     <= '0;
            best_stamp_reg   <= '0;
            pg_reg           <= '0;
            oor_reg          <= 1'b0;
            f_reg            <= '0;
            fault_reg        <= 1'b0;
            hit_reg          <= 1'b0;
            res_frame_reg    <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_next == ST_IDLE) && (state_reg != ST_IDLE) &&
                         (state_reg != ST_CLEAR);
            scan_cnt_reg <= (state_next == state_reg) ? scan_cnt_reg + SCAN_W'(1) : '0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PAGE_SHIFT:  page_shift_reg  <= cfg_data;
                    REG_PAGE_POLICY: page_policy_reg <= cfg_data[0];
                    REG_TLB_POLICY:  tlb_policy_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                ST_CLEAR:
                    clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
                ST_IDLE:
                    if (start)
                    begin
                        pg_reg        <= pg_full[PAGE_W-1:0];
                        oor_reg       <= (pg_full >= ADDR_W'(VIRTUAL_PAGES));
                        hit_reg       <= 1'b0;
                        fault_reg     <= 1'b0;
                        res_frame_reg <= '0;
                    end
                ST_LOOK:
                    if (!oor_reg)
                    begin
                        if (hit_any)
                        begin
                            hit_reg       <= 1'b1;
                            res_frame_reg <= tlb_frame_reg[hit_idx];
                            if (tlb_policy_reg)
                            begin
                                tlb_clock_reg          <= tlb_clock_inc;
                                tlb_stamp_reg[hit_idx] <= tlb_clock_inc;
                            end
                        end
                        else
                        begin
                            miss_count_reg <= sat_inc(miss_count_reg);
                        end
                    end
                ST_PT:
                begin
                    f_reg         <= f_sel;
                    res_frame_reg <= f_sel;
                    fault_reg     <= !pt_rdata_reg.resident;
                    if (!pt_rdata_reg.resident)
                        fault_count_reg <= sat_inc(fault_count_reg);
                end
                ST_FR:
                begin
                    // Invalidate slots of the evicted page, sparing the slot
                    // being filled.
                    for (int k = 0; k < TLB_ENTRIES; k++)
                    begin
                        if (fault_reg && SLOT_W'(k) != tlb_victim_reg &&
                            tlb_page_reg[k] == fr_rdata_reg.owner)
                            tlb_valid_reg[k] <= 1'b0;
                    end
                    tlb_page_reg[tlb_victim_reg]  <= pg_reg;
                    tlb_frame_reg[tlb_victim_reg] <= f_reg;
                    tlb_valid_reg[tlb_victim_reg] <= 1'b1;
                    if (page_policy_reg)
                        page_clock_reg <= page_clock_inc;
                    else if (fault_reg)
                        frame_victim_reg <= (f_reg == FIDX_W'(FRAMES - 1)) ?
                                            '0 : f_reg + FIDX_W'(1);
                    if (tlb_policy_reg)
                    begin
                        tlb_clock_reg                 <= tlb_clock_inc;
                        tlb_stamp_reg[tlb_victim_reg] <= tlb_clock_inc;
                    end
                    else
                    begin
                        tlb_victim_reg <= (tlb_victim_reg == SLOT_W'(TLB_ENTRIES - 1)) ?
                                          '0 : tlb_victim_reg + SLOT_W'(1);
                    end
                end
                ST_FSCAN:
                    if (scan_cnt_reg != '0 && fs_take)
                    begin
                        best_stamp_reg   <= fr_rdata_reg.stamp;
                        frame_victim_reg <= fs_idx;
                    end
                ST_TSCAN:
                    if (ts_take)
                    begin
                        best_stamp_reg <= ts_stamp;
                        tlb_victim_reg <= scan_cnt_reg[SLOT_W-1:0];
                    end
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tpr_checker.sv -----
`default_nettype none
`include "tlb_page_replacement_mmu_macros.svh"
module tpr_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        tlb_hit,
    input wire logic        page_fault,
    input wire logic        out_of_range,
    input wire logic [31:0] tlb_miss_total,
    input wire logic [31:0] page_fault_total
);
    `TPR_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `TPR_ASSERT_NOW(a_done_after_work, clk, rst_n, done, !busy && $past(busy))
    `TPR_ASSERT_NOW(a_flags_exclusive, clk, rst_n, done,
        !(tlb_hit && page_fault) && !(out_of_range && (tlb_hit || page_fault)))
    `TPR_ASSERT_NOW(a_totals_hold_idle, clk, rst_n, !busy && !$past(busy),
        $stable(tlb_miss_total) && $stable(page_fault_total))
endmodule

bind tlb_page_replacement_mmu tpr_checker u_tpr_checker (.*);
`default_nettype wire
